// ----- rtl/smith_waterman_affine_int8_assert.svh -----
// ----------------------------------------------------------------------------
// smith_waterman_affine_int8_assert.svh
// assertion macros for the alignment scorer rtl
// ----------------------------------------------------------------------------
`ifndef SMITH_WATERMAN_AFFINE_INT8_ASSERT_SVH
`define SMITH_WATERMAN_AFFINE_INT8_ASSERT_SVH

`ifndef SYNTHESIS

// clocked check, off while reset is asserted
`define SWA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define SWA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SWA_ASSERT(lbl, prop, msg)
`define SWA_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- rtl/swa_pkg.sv -----
// ----------------------------------------------------------------------------
// swa_pkg
// shared types, sizes and saturating arithmetic for the alignment scorer
// ----------------------------------------------------------------------------
package swa_pkg;

    localparam int MAX_QUERY_LEN = 1024;
    localparam int ROW_W = (MAX_QUERY_LEN > 1) ? $clog2(MAX_QUERY_LEN) : 1;
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_QUERY_LEN - 1);

    localparam int SCORE_W = 8;
    localparam int PEN_W   = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_GAP_OPEN   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_EXTEND = 1'b1;

    localparam logic [PEN_W-1:0] GAP_OPEN_RESET   = 7'd12;
    localparam logic [PEN_W-1:0] GAP_EXTEND_RESET = 7'd1;

    localparam logic signed [SCORE_W-1:0] SCORE_MIN       = 8'sh80;
    localparam logic signed [SCORE_W-1:0] SCORE_MAX       = 8'sh7F;
    localparam logic [SCORE_W-1:0]        FINAL_SCORE_TOP = 8'hFF;

    typedef logic signed [SCORE_W-1:0] score_t;

    typedef struct packed {
        logic first_row;
        logic new_sequence;
        logic last_cell;
    } cell_ctrl_t;

    typedef struct packed {
        logic [PEN_W-1:0] open_pen;
        logic [PEN_W-1:0] ext_pen;
    } gap_cfg_t;

    typedef struct packed {
        score_t h;
        score_t e;
    } row_entry_t;

    function automatic score_t sat_add(input score_t a, input score_t b);
        logic signed [SCORE_W:0] s;
        s = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
        if (s > 9'sd127)
            return SCORE_MAX;
        else if (s < -9'sd128)
            return SCORE_MIN;
        return s[SCORE_W-1:0];
    endfunction

    // penalty is unsigned, so only the floor can be hit
    function automatic score_t sat_sub(input score_t a, input logic [PEN_W-1:0] p);
        logic signed [SCORE_W:0] s;
        s = {a[SCORE_W-1], a} - $signed({2'b00, p});
        if (s < -9'sd128)
            return SCORE_MIN;
        return s[SCORE_W-1:0];
    endfunction

    function automatic score_t max8(input score_t a, input score_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ----- rtl/swa_ram.sv -----
// ----------------------------------------------------------------------------
// swa_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module swa_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read-first: a same-address write in this cycle is not seen
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/swa_cell.sv -----
// ----------------------------------------------------------------------------
// swa_cell
// one matrix cell update: h, gaps, diagonal and best-score registers
// ----------------------------------------------------------------------------
module swa_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  swa_pkg::cell_ctrl_t ctrl,
    input  swa_pkg::score_t     subst,
    input  swa_pkg::row_entry_t stored,
    input  swa_pkg::gap_cfg_t   cfg,
    output swa_pkg::row_entry_t updated,
    output logic                res_valid,
    output logic [7:0]          res_score,
    output logic                res_overflow
);
    import swa_pkg::*;

    score_t diag_reg, diag_next;
    score_t vgap_reg, vgap_next;
    score_t best_reg, best_next;

    score_t diag_cur, vgap_cur, best_cur;
    score_t hs, es, h, hopen, best_upd;

    always_comb
    begin
        diag_cur = ctrl.first_row ? SCORE_MIN : diag_reg;
        vgap_cur = ctrl.first_row ? SCORE_MIN : vgap_reg;
        best_cur = (ctrl.first_row && ctrl.new_sequence) ? SCORE_MIN : best_reg;

        hs = ctrl.new_sequence ? SCORE_MIN : stored.h;
        es = ctrl.new_sequence ? SCORE_MIN : stored.e;

        h        = max8(max8(sat_add(diag_cur, subst), vgap_cur), es);
        best_upd = max8(best_cur, h);
        hopen    = sat_sub(h, cfg.open_pen);

        updated.h = h;
        updated.e = max8(sat_sub(es, cfg.ext_pen), hopen);

        vgap_next = max8(sat_sub(vgap_cur, cfg.ext_pen), hopen);
        diag_next = hs;
        best_next = ctrl.last_cell ? SCORE_MIN : best_upd;

        res_valid    = fire && ctrl.last_cell;
        // adding the bias is a flip of the sign bit
        res_score    = {~best_upd[7], best_upd[6:0]};
        res_overflow = (best_upd == SCORE_MAX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diag_reg <= SCORE_MIN;
            vgap_reg <= SCORE_MIN;
            best_reg <= SCORE_MIN;
        end
        else if (fire)
        begin
            diag_reg <= diag_next;
            vgap_reg <= vgap_next;
            best_reg <= best_next;
        end
    end

endmodule

// ----- rtl/smith_waterman_affine_int8.sv -----
// ----------------------------------------------------------------------------
// smith_waterman_affine_int8
// local alignment scorer with affine gaps, biased 8-bit saturating scores
// ----------------------------------------------------------------------------
// Takes one matrix cell per clock while the input is not stalled, with no
// clearing pass after reset. A cell's row entry (stored H and E) is read
// from the row memory on the edge the cell is accepted, updated in stage
// two and written back on the edge stage two moves on, which a stalled
// output can delay; the result of a last cell enters the output register
// on that edge too. Back-to-back cells on the same row (one-row columns)
// are served by forwarding the write data. The stall on the input rises
// while a cell sits in stage two and a result beat waits in the output
// register under a stalled output; it drops in the cycle the held beat is
// taken. Configuration writes are always ready and must only be issued
// while the block is idle.
module smith_waterman_affine_int8 (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [swa_pkg::SCORE_W-1:0]  subst_score,
    input  logic                                first_row,
    input  logic                                new_sequence,
    input  logic                                last_cell,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [swa_pkg::SCORE_W-1:0]         final_score,
    output logic                                overflow,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [swa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [swa_pkg::PEN_W-1:0]           cfg_data
);
    import swa_pkg::*;

`include "smith_waterman_affine_int8_assert.svh"

    gap_cfg_t   cfg_reg;
    logic [ROW_W-1:0] row_index_reg;

    logic       s2_valid_reg;
    cell_ctrl_t s2_ctrl_reg;
    score_t     s2_subst_reg;
    logic [ROW_W-1:0] s2_row_reg;
    logic       fwd_reg;
    row_entry_t fwd_data_reg;

    logic       out_valid_reg;
    logic [SCORE_W-1:0] score_reg;
    logic       overflow_reg;

    logic       in_accept, s2_fire;
    logic [ROW_W-1:0] rd_row;
    row_entry_t ram_rd, stored, updated;
    logic       res_valid, res_overflow;
    logic [SCORE_W-1:0] res_score;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.open_pen <= GAP_OPEN_RESET;
            cfg_reg.ext_pen  <= GAP_EXTEND_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_GAP_OPEN:   cfg_reg.open_pen <= cfg_data;
                CFG_GAP_EXTEND: cfg_reg.ext_pen  <= cfg_data;
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    // stage two moves on unless a result beat waits and the output is still held
    assign s2_fire   = s2_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s2_valid_reg && !s2_fire;
    assign in_accept = in_valid && !in_stall;
    assign rd_row    = first_row ? '0 : row_index_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_index_reg <= '0;
            s2_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                row_index_reg <= (rd_row == ROW_LAST) ? '0 : rd_row + 1'b1;
                fwd_reg       <= s2_fire && (s2_row_reg == rd_row);
                s2_valid_reg  <= 1'b1;
            end
            else if (s2_fire)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s2_ctrl_reg.first_row    <= first_row;
            s2_ctrl_reg.new_sequence <= new_sequence;
            s2_ctrl_reg.last_cell    <= last_cell;
            s2_subst_reg             <= subst_score;
            s2_row_reg               <= rd_row;
            fwd_data_reg             <= updated;
        end
    end

    swa_ram #(
        .DEPTH (MAX_QUERY_LEN),
        .WIDTH (2 * SCORE_W),
        .AW    (ROW_W)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (s2_fire),
        .wr_addr (s2_row_reg),
        .wr_data (updated),
        .rd_en   (in_accept),
        .rd_addr (rd_row),
        .rd_data (ram_rd)
    );

    assign stored = fwd_reg ? fwd_data_reg : ram_rd;

    swa_cell u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (s2_fire),
        .ctrl         (s2_ctrl_reg),
        .subst        (s2_subst_reg),
        .stored       (stored),
        .cfg          (cfg_reg),
        .updated      (updated),
        .res_valid    (res_valid),
        .res_score    (res_score),
        .res_overflow (res_overflow)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            score_reg    <= res_score;
            overflow_reg <= res_overflow;
        end
    end

    assign out_valid   = out_valid_reg;
    assign final_score = score_reg;
    assign overflow    = overflow_reg;

    `SWA_ASSERT_ALWAYS(a_stall_needs_busy, in_stall |-> s2_valid_reg, "stall with stage two empty")
    `SWA_ASSERT(a_last_gives_beat, (s2_fire && s2_ctrl_reg.last_cell) |=> out_valid, "no result beat")
    `SWA_ASSERT(a_overflow_score, (out_valid && overflow) |-> (final_score == FINAL_SCORE_TOP), "bad overflow")
    `SWA_ASSERT(a_fwd_on_hit, (in_accept && s2_fire && (s2_row_reg == rd_row)) |=> fwd_reg, "no forward")

endmodule
